// ===== rtl/core/sha1pm_pkg.sv =====
// Package for the SHA-1 midstate prefix match unit.
// Holds pipeline types, register index codes and the round functions.
// No dependencies.
`timescale 1ns / 1ps

package sha1pm_pkg;

  localparam int unsigned NumRounds = 80;
  localparam int unsigned RndW      = 7;
  localparam int unsigned SaltW     = 48;
  localparam int unsigned InW       = 560;  // 48 + 8 * 64, whole bytes
  localparam int unsigned OutW      = 216;  // 1 + 64 + 64 + 32 + 48 = 209, padded
  localparam int unsigned OutPadW   = 7;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 64;

  localparam logic [CfgIdxW-1:0] REG_MIDSTATE_AB  = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_MIDSTATE_CD  = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_MIDSTATE_E   = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_MATCH_MASK   = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_MATCH_TARGET = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_SECOND_EN    = 3'd5;

  localparam logic [31:0] K0 = 32'h5A827999;
  localparam logic [31:0] K1 = 32'h6ED9EBA1;
  localparam logic [31:0] K2 = 32'h8F1BBCDC;
  localparam logic [31:0] K3 = 32'hCA62C1D6;

  typedef struct packed {
    logic [31:0]       a;
    logic [31:0]       b;
    logic [31:0]       c;
    logic [31:0]       d;
    logic [31:0]       e;
    logic [15:0][31:0] w;    // sliding schedule window, w[0] is the current word
    logic [SaltW-1:0]  salt;
  } state_t;

  typedef struct packed {
    logic [63:0] midstate_ab;
    logic [63:0] midstate_cd;
    logic [31:0] midstate_e;
    logic [63:0] match_mask;
    logic [63:0] match_target;
    logic        second_en;
  } cfg_t;

  function automatic logic [31:0] rotl1(input logic [31:0] x);
    return {x[30:0], x[31]};
  endfunction

  function automatic logic [31:0] rotl5(input logic [31:0] x);
    return {x[26:0], x[31:27]};
  endfunction

  function automatic logic [31:0] rotl30(input logic [31:0] x);
    return {x[1:0], x[31:2]};
  endfunction

  function automatic logic [31:0] round_k(input logic [RndW-1:0] t);
    logic [31:0] k;
    priority if (t < RndW'(20)) k = K0;
    else if (t < RndW'(40))     k = K1;
    else if (t < RndW'(60))     k = K2;
    else                        k = K3;
    return k;
  endfunction

  function automatic logic [31:0] round_f(input logic [RndW-1:0] t,
                                          input logic [31:0] b,
                                          input logic [31:0] c,
                                          input logic [31:0] d);
    logic [31:0] f;
    priority if (t < RndW'(20)) f = (b & c) | (~b & d);
    else if (t < RndW'(40))     f = b ^ c ^ d;
    else if (t < RndW'(60))     f = (b & c) | (b & d) | (c & d);
    else                        f = b ^ c ^ d;
    return f;
  endfunction

endpackage

// ===== rtl/core/sha1_midstate_prefix_match_unit.sv =====
// SHA-1 compression from a configured midstate with masked digest prefix match.
// Pipeline: 80 round stages followed by one feed-forward/compare stage.
// Throughput: one request per cycle;
// the whole pipeline holds while a result waits on m_tready.
// Reset: asynchronous, clears all valid bits and the configuration registers.
// Depends on sha1pm_pkg, sha1pm_round, sha1pm_final.
`timescale 1ns / 1ps

module sha1_midstate_prefix_match_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // configuration write port
  input  logic                              cfg_we_i,
  input  logic [sha1pm_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [sha1pm_pkg::CfgDataW-1:0]   cfg_data_i,
  // request stream
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // salt_tag[47:0], msg_w0_w1[111:48], msg_w2_w3, msg_w4_w5, msg_w6_w7,
  // msg_w8_w9, msg_w10_w11, msg_w12_w13, msg_w14_w15[559:496]
  input  logic [sha1pm_pkg::InW-1:0]        s_tdata,
  // result stream
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // match_found[0], digest_h0_h1[64:1], digest_h2_h3[128:65], digest_h4[160:129],
  // salt_tag_out[208:161], zero pad[215:209]
  output logic [sha1pm_pkg::OutW-1:0]       m_tdata
);

  sha1pm_pkg::cfg_t   cfg_q;
  logic               adv;
  logic               vld [sha1pm_pkg::NumRounds+1];
  sha1pm_pkg::state_t st  [sha1pm_pkg::NumRounds+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        sha1pm_pkg::REG_MIDSTATE_AB:  cfg_q.midstate_ab  <= cfg_data_i;
        sha1pm_pkg::REG_MIDSTATE_CD:  cfg_q.midstate_cd  <= cfg_data_i;
        sha1pm_pkg::REG_MIDSTATE_E:   cfg_q.midstate_e   <= cfg_data_i[31:0];
        sha1pm_pkg::REG_MATCH_MASK:   cfg_q.match_mask   <= cfg_data_i;
        sha1pm_pkg::REG_MATCH_TARGET: cfg_q.match_target <= cfg_data_i;
        sha1pm_pkg::REG_SECOND_EN:    cfg_q.second_en    <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign adv      = !m_tvalid || m_tready;
  assign s_tready = adv;

  always_comb begin
    vld[0]     = s_tvalid;
    st[0].a    = cfg_q.midstate_ab[63:32];
    st[0].b    = cfg_q.midstate_ab[31:0];
    st[0].c    = cfg_q.midstate_cd[63:32];
    st[0].d    = cfg_q.midstate_cd[31:0];
    st[0].e    = cfg_q.midstate_e;
    st[0].salt = s_tdata[sha1pm_pkg::SaltW-1:0];
    for (int k = 0; k < 8; k++) begin
      st[0].w[2*k]   = s_tdata[sha1pm_pkg::SaltW + 64*k + 32 +: 32];
      st[0].w[2*k+1] = s_tdata[sha1pm_pkg::SaltW + 64*k      +: 32];
    end
  end

  for (genvar r = 0; r < sha1pm_pkg::NumRounds; r++) begin : g_round
    sha1pm_round u_round (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (adv),
      .rnd_i   (sha1pm_pkg::RndW'(r)),
      .valid_i (vld[r]),
      .st_i    (st[r]),
      .valid_o (vld[r+1]),
      .st_o    (st[r+1])
    );
  end

  sha1pm_final u_final (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (vld[sha1pm_pkg::NumRounds]),
    .st_i    (st[sha1pm_pkg::NumRounds]),
    .cfg_i   (cfg_q),
    .valid_o (m_tvalid),
    .data_o  (m_tdata)
  );

endmodule

// ===== rtl/core/sha1pm_round.sv =====
// One SHA-1 round stage: round update plus schedule window shift, registered.
// Depends on sha1pm_pkg.
`timescale 1ns / 1ps

module sha1pm_round (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  logic [sha1pm_pkg::RndW-1:0]  rnd_i,
  input  logic                         valid_i,
  input  sha1pm_pkg::state_t           st_i,
  output logic                         valid_o,
  output sha1pm_pkg::state_t           st_o
);

  logic               valid_q;
  sha1pm_pkg::state_t st_q, st_d;
  logic [31:0]        f, sum, w_new;

  always_comb begin
    f     = sha1pm_pkg::round_f(rnd_i, st_i.b, st_i.c, st_i.d);
    sum   = sha1pm_pkg::rotl5(st_i.a) + f + st_i.e + sha1pm_pkg::round_k(rnd_i) + st_i.w[0];
    w_new = sha1pm_pkg::rotl1(st_i.w[13] ^ st_i.w[8] ^ st_i.w[2] ^ st_i.w[0]);
    st_d      = st_i;
    st_d.a    = sum;
    st_d.b    = st_i.a;
    st_d.c    = sha1pm_pkg::rotl30(st_i.b);
    st_d.d    = st_i.c;
    st_d.e    = st_i.d;
    st_d.w    = {w_new, st_i.w[15:1]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      st_q <= st_d;
    end
  end

  assign valid_o = valid_q;
  assign st_o    = st_q;

endmodule

// ===== rtl/core/sha1pm_final.sv =====
// Final stage: midstate feed-forward, masked prefix compare, output register.
// Depends on sha1pm_pkg.
`timescale 1ns / 1ps

module sha1pm_final (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          valid_i,
  input  sha1pm_pkg::state_t            st_i,
  input  sha1pm_pkg::cfg_t              cfg_i,
  output logic                          valid_o,
  output logic [sha1pm_pkg::OutW-1:0]   data_o
);

  logic [31:0]                 d0, d1, d2, d3, d4;
  logic                        hit_w0, hit_w1, match;
  logic                        valid_q;
  logic [sha1pm_pkg::OutW-1:0] data_q, data_d;

  always_comb begin
    d0     = cfg_i.midstate_ab[63:32] + st_i.a;
    d1     = cfg_i.midstate_ab[31:0]  + st_i.b;
    d2     = cfg_i.midstate_cd[63:32] + st_i.c;
    d3     = cfg_i.midstate_cd[31:0]  + st_i.d;
    d4     = cfg_i.midstate_e         + st_i.e;
    hit_w0 = (d0 & cfg_i.match_mask[63:32]) == cfg_i.match_target[63:32];
    hit_w1 = (d1 & cfg_i.match_mask[31:0])  == cfg_i.match_target[31:0];
    match  = hit_w0 && (!cfg_i.second_en || hit_w1);
    data_d = {{sha1pm_pkg::OutPadW{1'b0}}, st_i.salt, d4, d2, d3, d0, d1, match};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule
